// File: rtl/lees_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lees_pkg
// Shared types, codes and register defaults for the edge escape sequencer.
// ----------------------------------------------------------------------------
package lees_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    typedef enum logic [2:0] {
        PH_NONE    = 3'd0,
        PH_BRAKE   = 3'd1,
        PH_REVERSE = 3'd2,
        PH_FTURN   = 3'd3,
        PH_STURN   = 3'd4,
        PH_FORWARD = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_BRAKE  = 3'd1,
        CMD_BACK   = 3'd2,
        CMD_FWD    = 3'd3,
        CMD_ROTATE = 3'd4,
        CMD_STOP   = 3'd5
    } motor_cmd_t;

    typedef enum logic [2:0] {
        RI_FRONT_BRAKE    = 3'd0,
        RI_FRONT_MIN_BACK = 3'd1,
        RI_FRONT_MAX_BACK = 3'd2,
        RI_REAR_CONFIRM   = 3'd3,
        RI_FRONT_TURN     = 3'd4,
        RI_SIDE_TURN      = 3'd5,
        RI_BACK_FORWARD   = 3'd6
    } reg_idx_t;

    localparam logic [CFG_W-1:0] FRONT_BRAKE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] FRONT_MIN_BACK_RST = 16'd150;
    localparam logic [CFG_W-1:0] FRONT_MAX_BACK_RST = 16'd400;
    localparam logic [CFG_W-1:0] REAR_CONFIRM_RST   = 16'd30;
    localparam logic [CFG_W-1:0] FRONT_TURN_RST     = 16'd250;
    localparam logic [CFG_W-1:0] SIDE_TURN_RST      = 16'd200;
    localparam logic [CFG_W-1:0] BACK_FORWARD_RST   = 16'd300;

    typedef struct packed {
        logic [CFG_W-1:0] front_brake_ms;
        logic [CFG_W-1:0] front_min_back_ms;
        logic [CFG_W-1:0] front_max_back_ms;
        logic [CFG_W-1:0] rear_confirm_ms;
        logic [CFG_W-1:0] front_turn_ms;
        logic [CFG_W-1:0] side_turn_ms;
        logic [CFG_W-1:0] back_forward_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              front_left;
        logic              front_right;
        logic              left_edge;
        logic              right_edge;
        logic              back_edge;
    } in_item_t;

    typedef struct packed {
        logic       active;
        logic [2:0] motor_cmd;
        logic       turn_dir;
        logic       search_reset;
        logic [2:0] escape_phase;
    } out_item_t;

endpackage

// File: rtl/lees_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lees_apb_regs
// APB register file holding the seven escape timing registers.
// ----------------------------------------------------------------------------
module lees_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lees_pkg::APB_AW-1:0] paddr,
    input  logic [lees_pkg::APB_DW-1:0] pwdata,
    output logic [lees_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output lees_pkg::cfg_t              cfg
);
    import lees_pkg::*;

    cfg_t             cfg_reg;
    logic             wr_en;
    reg_idx_t         idx;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wval   = pwdata[CFG_W-1:0];
    assign cfg    = cfg_reg;
    assign prdata = {{(APB_DW-CFG_W){1'b0}}, rval};

    always_comb begin
        unique case (idx)
            RI_FRONT_BRAKE:    rval = cfg_reg.front_brake_ms;
            RI_FRONT_MIN_BACK: rval = cfg_reg.front_min_back_ms;
            RI_FRONT_MAX_BACK: rval = cfg_reg.front_max_back_ms;
            RI_REAR_CONFIRM:   rval = cfg_reg.rear_confirm_ms;
            RI_FRONT_TURN:     rval = cfg_reg.front_turn_ms;
            RI_SIDE_TURN:      rval = cfg_reg.side_turn_ms;
            RI_BACK_FORWARD:   rval = cfg_reg.back_forward_ms;
            default:           rval = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.front_brake_ms    <= FRONT_BRAKE_RST;
            cfg_reg.front_min_back_ms <= FRONT_MIN_BACK_RST;
            cfg_reg.front_max_back_ms <= FRONT_MAX_BACK_RST;
            cfg_reg.rear_confirm_ms   <= REAR_CONFIRM_RST;
            cfg_reg.front_turn_ms     <= FRONT_TURN_RST;
            cfg_reg.side_turn_ms      <= SIDE_TURN_RST;
            cfg_reg.back_forward_ms   <= BACK_FORWARD_RST;
        end else if (wr_en) begin
            // addresses past the last register are dropped
            unique case (idx)
                RI_FRONT_BRAKE:    cfg_reg.front_brake_ms    <= wval;
                RI_FRONT_MIN_BACK: cfg_reg.front_min_back_ms <= wval;
                RI_FRONT_MAX_BACK: cfg_reg.front_max_back_ms <= wval;
                RI_REAR_CONFIRM:   cfg_reg.rear_confirm_ms   <= wval;
                RI_FRONT_TURN:     cfg_reg.front_turn_ms     <= wval;
                RI_SIDE_TURN:      cfg_reg.side_turn_ms      <= wval;
                RI_BACK_FORWARD:   cfg_reg.back_forward_ms   <= wval;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/lees_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lees_step
// Escape state machine: holds phase, direction and timers, and computes the
// result of one sensor item against the current state.
// ----------------------------------------------------------------------------
module lees_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  lees_pkg::in_item_t  item,
    input  lees_pkg::cfg_t      cfg,
    output lees_pkg::out_item_t res
);
    import lees_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              dir_reg, dir_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] rear_reg, rear_next;

    logic              fl, fr, le, re, bk;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] rear_hold;
    logic              idle;
    logic              done;
    logic              turn_now;
    motor_cmd_t        cmd;
    phase_t            cur;

    assign now = item.now_ms;
    assign fl  = item.front_left;
    assign fr  = item.front_right;
    assign le  = item.left_edge;
    assign re  = item.right_edge;
    assign bk  = item.back_edge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NONE;
            dir_reg   <= 1'b0;
            start_reg <= '0;
            rear_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            start_reg <= start_next;
            rear_reg  <= rear_next;
        end
    end

    always_comb begin
        cur        = phase_reg;
        dir_next   = dir_reg;
        start_next = start_reg;
        rear_next  = rear_reg;
        idle       = 1'b0;
        done       = 1'b0;
        turn_now   = 1'b0;
        cmd        = CMD_NONE;
        rear_hold  = '0;

        // start an escape when none is running
        if (cur == PH_NONE) begin
            if (fl || fr) begin
                cur = PH_BRAKE;
                dir_next = fr && !fl;
            end else if (le) begin
                cur = PH_STURN;
                dir_next = 1'b0;
            end else if (re) begin
                cur = PH_STURN;
                dir_next = 1'b1;
            end else if (bk) begin
                cur = PH_FORWARD;
                dir_next = 1'b0;
            end else begin
                idle = 1'b1;
            end
            start_next = now;
            rear_next  = '0;
            if (idle) begin
                start_next = start_reg;
                rear_next  = rear_reg;
            end
        end

        elapsed    = now - start_next;
        phase_next = cur;

        unique case (cur)
            PH_BRAKE: begin
                cmd = CMD_BRAKE;
                if (elapsed >= TIME_W'(cfg.front_brake_ms)) begin
                    phase_next = PH_REVERSE;
                    start_next = now;
                end
            end
            PH_REVERSE: begin
                if (bk && rear_next == '0) begin
                    rear_next = now;
                end else if (!bk) begin
                    rear_next = '0;
                end
                rear_hold = now - rear_next;
                turn_now = (rear_next != '0 && rear_hold >= TIME_W'(cfg.rear_confirm_ms))
                        || elapsed >= TIME_W'(cfg.front_max_back_ms)
                        || (elapsed >= TIME_W'(cfg.front_min_back_ms) && !fl && !fr);
                if (turn_now) begin
                    phase_next = PH_FTURN;
                    start_next = now;
                    cmd = CMD_ROTATE;
                end else begin
                    cmd = CMD_BACK;
                end
            end
            PH_FTURN: begin
                cmd = CMD_ROTATE;
                if (elapsed >= TIME_W'(cfg.front_turn_ms)) begin
                    phase_next = PH_NONE;
                    done = 1'b1;
                end
            end
            PH_STURN: begin
                cmd = CMD_ROTATE;
                if (elapsed >= TIME_W'(cfg.side_turn_ms)) begin
                    phase_next = PH_NONE;
                    done = 1'b1;
                end
            end
            PH_FORWARD: begin
                if (fl || fr) begin
                    cmd = CMD_STOP;
                    phase_next = PH_FTURN;
                    start_next = now;
                end else begin
                    cmd = CMD_FWD;
                    if (elapsed >= TIME_W'(cfg.back_forward_ms) && !bk) begin
                        phase_next = PH_NONE;
                        done = 1'b1;
                    end
                end
            end
            default: begin
                // no escape running: hold everything
                phase_next = PH_NONE;
            end
        endcase

        if (idle) begin
            res = '0;
        end else begin
            res.active       = 1'b1;
            res.motor_cmd    = cmd;
            res.turn_dir     = dir_next;
            res.search_reset = done;
            res.escape_phase = phase_next;
        end
    end

    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.search_reset |=> phase_reg == PH_NONE)
        else $error("finished escape left a phase running");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !res.active |=> phase_reg == PH_NONE && $stable(start_reg))
        else $error("idle item changed escape state");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_reg) && $stable(dir_reg) && $stable(rear_reg))
        else $error("state moved without an item");

    a_phase_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.active |=> phase_reg == phase_t'($past(res.escape_phase)))
        else $error("reported phase differs from stored phase");

endmodule

// File: rtl/line_edge_escape_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edge_escape_sequencer
// Edge escape sequencer: an input register, the escape state machine, and a
// result register, with an APB port for the seven timing registers.
// ----------------------------------------------------------------------------
// Item accept to result valid passes through the input reg and the result reg.
// Throughput: 1 item per cycle while m_ready does not stall the result register.
// Reset (aresetn low, synchronous): pipeline empty, phase none, direction
// right, timers cleared, timing registers at their defaults.
// ----------------------------------------------------------------------------
module line_edge_escape_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lees_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lees_pkg::out_item_t         m_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lees_pkg::APB_AW-1:0] paddr,
    input  logic [lees_pkg::APB_DW-1:0] pwdata,
    output logic [lees_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import lees_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t m_item_reg;
    logic      m_valid_reg;
    out_item_t res;
    logic      advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    lees_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lees_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            m_item_reg <= res;
        end
    end

endmodule

// File: dv/tb_line_edge_escape_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_edge_escape_sequencer
// Self-checking bench for the edge escape sequencer. Sensor items with
// timestamps go in over a valid/ready channel. A behavioral copy of the
// escape state machine computes each result, and the result channel is
// checked in order. The seven timing registers are read back over APB and
// stepped through defaults, zero, maximum and random settings. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_line_edge_escape_sequencer;
    import lees_pkg::*;

    localparam int NUM_TIMING  = 7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_LIMIT = 60;
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(NUM_TIMING * 4);

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_item;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    line_edge_escape_sequencer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // escape state as the block should hold it
    logic [CFG_W-1:0]  timing [NUM_TIMING];
    logic [CFG_W-1:0]  next_timing [NUM_TIMING];
    phase_t            esc_phase = PH_NONE;
    logic              esc_dir = 1'b0;
    logic [TIME_W-1:0] esc_start = '0;
    logic [TIME_W-1:0] rear_since = '0;

    out_item_t escape_expect_q [$];
    int        err_count = 0;
    int        cycle_count = 0;

    // sender and receiver pacing
    int tx_gap_max = 0;
    int tx_burst_left = 0;
    int rx_mode = RX_ALWAYS;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int rx_tick = 0;

    logic [TIME_W-1:0] clock_ms = '0;

    function automatic void begin_escape(phase_t ph, logic dir, logic [TIME_W-1:0] now);
        esc_phase  = ph;
        esc_dir    = dir;
        esc_start  = now;
        rear_since = '0;
    endfunction

    function automatic out_item_t predict_escape(in_item_t it);
        out_item_t         r;
        motor_cmd_t        cmd;
        logic              done;
        logic              front;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] held;

        r     = '0;
        cmd   = CMD_NONE;
        done  = 1'b0;
        front = it.front_left | it.front_right;

        if (esc_phase == PH_NONE) begin
            if (front)
                begin_escape(PH_BRAKE, it.front_right & ~it.front_left, it.now_ms);
            else if (it.left_edge)
                begin_escape(PH_STURN, 1'b0, it.now_ms);
            else if (it.right_edge)
                begin_escape(PH_STURN, 1'b1, it.now_ms);
            else if (it.back_edge)
                begin_escape(PH_FORWARD, 1'b0, it.now_ms);
            else
                return r;
        end

        elapsed = it.now_ms - esc_start;
        case (esc_phase)
            PH_BRAKE: begin
                cmd = CMD_BRAKE;
                if (elapsed >= timing[RI_FRONT_BRAKE]) begin
                    esc_phase = PH_REVERSE;
                    esc_start = it.now_ms;
                end
            end
            PH_REVERSE: begin
                // zero marks the rear timer unset, so a hit at time zero is lost
                if (it.back_edge && rear_since == '0)
                    rear_since = it.now_ms;
                else if (!it.back_edge)
                    rear_since = '0;
                held = it.now_ms - rear_since;
                if ((rear_since != '0 && held >= timing[RI_REAR_CONFIRM])
                        || elapsed >= timing[RI_FRONT_MAX_BACK]
                        || (elapsed >= timing[RI_FRONT_MIN_BACK] && !front)) begin
                    esc_phase = PH_FTURN;
                    esc_start = it.now_ms;
                    cmd       = CMD_ROTATE;
                end else begin
                    cmd = CMD_BACK;
                end
            end
            PH_FTURN: begin
                cmd = CMD_ROTATE;
                if (elapsed >= timing[RI_FRONT_TURN]) begin
                    esc_phase = PH_NONE;
                    done      = 1'b1;
                end
            end
            PH_STURN: begin
                cmd = CMD_ROTATE;
                if (elapsed >= timing[RI_SIDE_TURN]) begin
                    esc_phase = PH_NONE;
                    done      = 1'b1;
                end
            end
            default: begin
                if (front) begin
                    cmd       = CMD_STOP;
                    esc_phase = PH_FTURN;
                    esc_start = it.now_ms;
                end else begin
                    cmd = CMD_FWD;
                    if (elapsed >= timing[RI_BACK_FORWARD] && !it.back_edge) begin
                        esc_phase = PH_NONE;
                        done      = 1'b1;
                    end
                end
            end
        endcase

        r.active       = 1'b1;
        r.motor_cmd    = cmd;
        r.turn_dir     = esc_dir;
        r.search_reset = done;
        r.escape_phase = esc_phase;
        return r;
    endfunction

    function automatic in_item_t sensor_item(logic [TIME_W-1:0] now, logic fl, logic fr,
                                             logic le, logic re, logic bk);
        in_item_t it;
        it.now_ms      = now;
        it.front_left  = fl;
        it.front_right = fr;
        it.left_edge   = le;
        it.right_edge  = re;
        it.back_edge   = bk;
        return it;
    endfunction

    // predict on accept, check on result
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn) begin
            if (s_valid && s_ready)
                escape_expect_q.push_back(predict_escape(s_item));
            if (m_valid && m_ready) begin
                if (escape_expect_q.size() == 0) begin
                    err_count++;
                    if (err_count <= PRINT_LIMIT)
                        $display("%0t: unexpected result, none pending, actual %p",
                                 $time, m_item);
                end else begin
                    e = escape_expect_q.pop_front();
                    if (m_item.active !== e.active || m_item.motor_cmd !== e.motor_cmd
                            || m_item.turn_dir !== e.turn_dir
                            || m_item.search_reset !== e.search_reset
                            || m_item.escape_phase !== e.escape_phase) begin
                        err_count++;
                        if (err_count <= PRINT_LIMIT)
                            $display({"%0t: result mismatch: expected act=%0b cmd=%0d dir=%0b ",
                                      "rst=%0b ph=%0d, actual act=%0b cmd=%0d dir=%0b ",
                                      "rst=%0b ph=%0d"},
                                     $time, e.active, e.motor_cmd, e.turn_dir,
                                     e.search_reset, e.escape_phase, m_item.active,
                                     m_item.motor_cmd, m_item.turn_dir,
                                     m_item.search_reset, m_item.escape_phase);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: long hold-off first, then the current stall pattern
    always @(negedge aclk) begin
        rx_tick++;
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_ready <= (rx_tick % 5) > 1;
                RX_SPARSE:   m_ready <= $urandom_range(0, 7) != 0;
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_sensor_item(in_item_t it);
        int gap;
        gap = 0;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        end
        tx_burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_results_drained(int settle);
        sender_idle();
        while (escape_expect_q.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr < UNMAPPED_ADDR)
            timing[addr[APB_AW-1:2]] = data[CFG_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            err_count++;
            $display("%0t: register read at %0d: expected %h, actual %h",
                     $time, addr, want, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // load next_timing once the block has gone quiet; upper data bits are junk
    task automatic program_timing();
        logic [APB_DW-1:0] data;
        wait_results_drained(4);
        for (int i = 0; i < NUM_TIMING; i++) begin
            data = {16'($urandom), next_timing[i]};
            apb_write(APB_AW'(i * 4), data);
        end
    endtask

    task automatic run_random_phase(int n_items, int max_step, int jump_odds,
                                    bit with_pressure);
        logic [3:0] hit_bits;
        int         hit_left;
        logic       back_hold;
        logic [3:0] side;
        logic       bk;
        in_item_t   it;
        hit_bits  = '0;
        hit_left  = 0;
        back_hold = 1'b0;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, jump_odds) == 0)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(0, max_step);
            // sensor hits come in short streaks, the rear sensor in longer holds
            if (hit_left == 0 && $urandom_range(0, 11) == 0) begin
                hit_bits = 4'($urandom_range(1, 15));
                hit_left = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 5) == 0)
                back_hold = ~back_hold;
            side = (hit_left > 0) ? hit_bits : 4'b0;
            if (hit_left > 0)
                hit_left--;
            bk = back_hold;
            if ($urandom_range(0, 9) == 0)
                {side, bk} = 5'($urandom);
            it = sensor_item(clock_ms, side[3], side[2], side[1], side[0], bk);

            if (with_pressure && n == n_items / 3) begin
                tx_gap_max  = 0;
                rx_hold_req = 300;
            end
            if (with_pressure && n == n_items / 3 + 40)
                tx_gap_max = 6;
            if (with_pressure && n == (2 * n_items) / 3)
                wait_results_drained(0);
            send_sensor_item(it);
        end
    endtask

    task automatic test_register_access();
        logic [CFG_W-1:0] defaults [NUM_TIMING];
        defaults = '{FRONT_BRAKE_RST, FRONT_MIN_BACK_RST, FRONT_MAX_BACK_RST,
                     REAR_CONFIRM_RST, FRONT_TURN_RST, SIDE_TURN_RST, BACK_FORWARD_RST};
        for (int i = 0; i < NUM_TIMING; i++)
            apb_read_check(APB_AW'(i * 4), {16'b0, defaults[i]});
        foreach (next_timing[i])
            next_timing[i] = 16'($urandom);
        program_timing();
        // out of range index must leave every register alone
        apb_write(UNMAPPED_ADDR, $urandom);
        for (int i = 0; i < NUM_TIMING; i++)
            apb_read_check(APB_AW'(i * 4), {16'b0, timing[i]});
    endtask

    task automatic test_directed_escapes();
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        next_timing = '{16'd0, 16'd10, 16'd20, 16'd3, 16'd0, 16'd0, 16'd5};
        program_timing();
        // idle at both ends of the time range
        send_sensor_item(sensor_item(32'h0, 0, 0, 0, 0, 0));
        send_sensor_item(sensor_item(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        // right front only turns left; time wraps; rear hit at zero is lost
        send_sensor_item(sensor_item(32'hFFFF_FFFE, 0, 1, 0, 0, 0));
        send_sensor_item(sensor_item(32'd0, 1, 0, 0, 0, 1));
        send_sensor_item(sensor_item(32'd1, 1, 0, 0, 0, 1));
        send_sensor_item(sensor_item(32'd4, 1, 0, 0, 0, 1));
        send_sensor_item(sensor_item(32'd4, 0, 0, 0, 0, 0));
        // both fronts: front held past the minimum, forced turn at the maximum
        send_sensor_item(sensor_item(32'd10, 1, 1, 1, 1, 1));
        send_sensor_item(sensor_item(32'd25, 1, 0, 0, 0, 0));
        send_sensor_item(sensor_item(32'd30, 1, 0, 0, 0, 0));
        send_sensor_item(sensor_item(32'd30, 0, 0, 0, 0, 0));
        // early turn once the fronts clear
        send_sensor_item(sensor_item(32'd40, 1, 0, 0, 0, 0));
        send_sensor_item(sensor_item(32'd50, 0, 0, 0, 0, 0));
        send_sensor_item(sensor_item(32'd50, 0, 0, 0, 0, 0));
        // side hits, left wins over right
        send_sensor_item(sensor_item(32'd60, 0, 0, 1, 1, 1));
        send_sensor_item(sensor_item(32'd61, 0, 0, 0, 1, 0));
        // back hit, then a front hit while driving forward
        send_sensor_item(sensor_item(32'd70, 0, 0, 0, 0, 1));
        send_sensor_item(sensor_item(32'd72, 1, 0, 0, 0, 0));
        send_sensor_item(sensor_item(32'd72, 0, 0, 0, 0, 0));
        // forward held by the rear sensor past its time
        send_sensor_item(sensor_item(32'd80, 0, 0, 0, 0, 1));
        send_sensor_item(sensor_item(32'd85, 0, 0, 0, 0, 1));
        send_sensor_item(sensor_item(32'd86, 0, 0, 0, 0, 0));
    endtask

    task automatic test_default_timing();
        next_timing = '{FRONT_BRAKE_RST, FRONT_MIN_BACK_RST, FRONT_MAX_BACK_RST,
                        REAR_CONFIRM_RST, FRONT_TURN_RST, SIDE_TURN_RST, BACK_FORWARD_RST};
        program_timing();
        tx_gap_max = 6;
        rx_mode    = RX_RANDOM;
        run_random_phase(400, 25, 200, 1'b1);
    endtask

    task automatic test_zero_timing();
        foreach (next_timing[i])
            next_timing[i] = '0;
        program_timing();
        tx_gap_max = 0;
        rx_mode    = RX_PERIODIC;
        run_random_phase(250, 3, 100, 1'b0);
    endtask

    task automatic test_max_timing();
        foreach (next_timing[i])
            next_timing[i] = '1;
        program_timing();
        tx_gap_max = 3;
        rx_mode    = RX_SPARSE;
        run_random_phase(300, 2000, 40, 1'b0);
    endtask

    task automatic test_small_timing();
        for (int k = 0; k < 3; k++) begin
            foreach (next_timing[i])
                next_timing[i] = 16'($urandom_range(0, 60));
            program_timing();
            tx_gap_max = (k == 1) ? 0 : 4;
            rx_mode    = (k == 1) ? RX_ALWAYS : RX_RANDOM;
            run_random_phase(150, 10, 300, 1'b0);
        end
    endtask

    task automatic test_random_timing();
        foreach (next_timing[i])
            next_timing[i] = 16'($urandom_range(0, 65535));
        program_timing();
        tx_gap_max = 5;
        rx_mode    = RX_SPARSE;
        run_random_phase(300, 5000, 30, 1'b0);
    endtask

    task automatic test_extreme_mix();
        foreach (next_timing[i])
            next_timing[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        program_timing();
        tx_gap_max = 2;
        rx_mode    = RX_PERIODIC;
        run_random_phase(250, 3000, 20, 1'b0);
    endtask

    initial begin
        timing = '{FRONT_BRAKE_RST, FRONT_MIN_BACK_RST, FRONT_MAX_BACK_RST,
                   REAR_CONFIRM_RST, FRONT_TURN_RST, SIDE_TURN_RST, BACK_FORWARD_RST};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_directed_escapes();
        test_default_timing();
        test_zero_timing();
        test_max_timing();
        test_small_timing();
        test_random_timing();
        test_extreme_mix();

        wait_results_drained(10);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lees_pkg.sv
rtl/lees_apb_regs.sv
rtl/lees_step.sv
rtl/line_edge_escape_sequencer.sv
dv/tb_line_edge_escape_sequencer.sv
